FILE: rtl/merge_sort_external_compare_assert.svh
// ----------------------------------------------------------------------------
// Merge sort assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MERGE_SORT_EXTERNAL_COMPARE_ASSERT_SVH
`define MERGE_SORT_EXTERNAL_COMPARE_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset
`define MSE_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent
`define MSE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequent holds in the cycle after its antecedent
`define MSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mse_pkg.sv
// ----------------------------------------------------------------------------
// Merge sort package
// Field widths, command and result codes and the register map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mse_pkg;

    // Payload field widths
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 6;
    localparam int IN_DW  = 8;
    localparam int OUT_DW = 24;

    // Input command codes (s_axis_tuser)
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_ANSWER = 1'b1;

    // Result kind codes (m_axis_tuser)
    localparam logic KIND_REQ = 1'b0;
    localparam logic KIND_POS = 1'b1;

    // Register map
    localparam int          APB_AW       = 2;
    localparam logic [1:0]  ADDR_REVERSE = 2'd0;

endpackage

FILE: rtl/mse_ram.sv
// ----------------------------------------------------------------------------
// Merge sort RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mse_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/merge_sort_external_compare.sv
// ----------------------------------------------------------------------------
// Merge sort with external comparison
// Stable bottom-up merge sort of item positions; key compares are answered
// by the requester through the input stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands: tuser 0 starts a sort of tdata[6:0] items
//   (saturated to MAX_ITEMS), tuser 1 answers the open compare request with
//   tdata[7]. m_axis carries results: tuser 0 is a compare request asking
//   whether key[first] < key[second], tuser 1 is one sorted original position,
//   tlast marks the final one. The APB register reverse swaps the operands of
//   every request for a descending sort.
//   A start loads the identity order into the order RAM, then each merge pass walks
//   its runs through one shared read port, copying tail items without asking
//   and issuing the next request after each answer. After the last pass the
//   positions are read back and leave one by one. s_axis_tready is high
//   only while idle or waiting for an answer; a start while waiting drops the
//   running sort, an answer while idle is ignored.
//   One output register holds the current result; while the receiver stalls
//   the sequencer waits before loading the next one. Synchronous reset
//   returns to idle with no result pending; the RAM contents need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module merge_sort_external_compare
    import mse_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DW-1:0]     s_axis_tdata,   // [6:0] length, [7] answer
    input  logic                 s_axis_tuser,   // [0] command
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_DW-1:0]    m_axis_tdata,   // [5:0] first_index,
                                                 // [11:6] second_index,
                                                 // [17:12] sorted_index
    output logic                 m_axis_tuser,   // [0] kind
    output logic                 m_axis_tlast,   // last
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    `include "merge_sort_external_compare_assert.svh"

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int WW = CW + 1;
    localparam int PW = CW + 2;
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_INIT = 4'd1;
    localparam logic [3:0] ST_PASS = 4'd2;
    localparam logic [3:0] ST_OPEN = 4'd3;
    localparam logic [3:0] ST_HEAD = 4'd4;
    localparam logic [3:0] ST_COPY = 4'd5;
    localparam logic [3:0] ST_CMPL = 4'd6;
    localparam logic [3:0] ST_CMPR = 4'd7;
    localparam logic [3:0] ST_REQ  = 4'd8;
    localparam logic [3:0] ST_WAIT = 4'd9;
    localparam logic [3:0] ST_EMRD = 4'd10;
    localparam logic [3:0] ST_EMLD = 4'd11;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_n, n_n;
    logic [WW-1:0] r_width, n_width;
    logic [PW-1:0] r_pstart, n_pstart;
    logic [CW-1:0] r_le, n_le;
    logic [CW-1:0] r_re, n_re;
    logic [CW-1:0] r_lp, n_lp;
    logic [CW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_op, n_op;
    logic [CW-1:0] r_x, n_x;
    logic          r_src, n_src;
    logic [AW-1:0] r_lhead, n_lhead;
    logic [AW-1:0] r_rhead, n_rhead;
    logic          r_reverse;

    logic              r_out_valid;
    logic              r_out_kind;
    logic [IDX_W-1:0]  r_out_a;
    logic [IDX_W-1:0]  r_out_b;
    logic [IDX_W-1:0]  r_out_s;
    logic              r_out_last;

    logic              w_load;
    logic              w_load_kind;
    logic [IDX_W-1:0]  w_load_a;
    logic [IDX_W-1:0]  w_load_b;
    logic [IDX_W-1:0]  w_load_s;
    logic              w_load_last;

    logic          w_in_acc;
    logic          w_out_free;
    logic [LEN_W-1:0] w_len;
    logic [CW-1:0] w_len_sat;
    logic          w_l_has;
    logic          w_r_has;
    logic [PW-1:0] w_end_l;
    logic [PW-1:0] w_end_r;
    logic [PW-1:0] w_n_ext;
    logic          w_is_last;
    logic          w_bal_ok;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_wdata;
    logic          w_wbank;
    logic [CW-1:0] w_raddr;
    logic [AW-1:0] w_rd0;
    logic [AW-1:0] w_rd1;
    logic [AW-1:0] w_rdata;

    // Handshake and decode
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) || (r_state == ST_WAIT);
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_len         = s_axis_tdata[LEN_W-1:0];
    assign w_len_sat     = (LW'(w_len) > LW'(MAX_ITEMS)) ? CW'(MAX_ITEMS) : CW'(w_len);

    // Run bounds for the next run pair
    assign w_n_ext  = PW'(r_n);
    assign w_end_l  = r_pstart + PW'(r_width);
    assign w_end_r  = r_pstart + {r_width, 1'b0};
    assign w_l_has  = r_lp < r_le;
    assign w_r_has  = r_rp < r_re;
    assign w_is_last = (CW'(r_x + 1'b1) == r_n);
    assign w_bal_ok  = (CW'(r_op + r_le) == CW'(r_lp + r_rp));

    // Ping-pong order RAMs: read the source bank, write the other
    assign w_rdata = r_src ? w_rd1 : w_rd0;

    mse_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_ITEMS)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_we && !w_wbank),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (AW'(w_raddr)),
        .o_rdata (w_rd0)
    );

    mse_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_ITEMS)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_we && w_wbank),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (AW'(w_raddr)),
        .o_rdata (w_rd1)
    );

    // Select the read address
    always_comb begin
        case (r_state)
            ST_CMPR, ST_REQ:  w_raddr = r_rp;
            ST_EMRD, ST_EMLD: w_raddr = r_x;
            default:          w_raddr = w_l_has ? r_lp : r_rp;
        endcase
    end

    // Sequence the sort
    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_width  = r_width;
        n_pstart = r_pstart;
        n_le     = r_le;
        n_re     = r_re;
        n_lp     = r_lp;
        n_rp     = r_rp;
        n_op     = r_op;
        n_x      = r_x;
        n_src    = r_src;
        n_lhead  = r_lhead;
        n_rhead  = r_rhead;

        w_we     = 1'b0;
        w_wbank  = !r_src;
        w_waddr  = AW'(r_op);
        w_wdata  = w_rdata;

        w_load      = 1'b0;
        w_load_kind = KIND_REQ;
        w_load_a    = '0;
        w_load_b    = '0;
        w_load_s    = '0;
        w_load_last = 1'b0;

        case (r_state)
            ST_IDLE, ST_WAIT: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == CMD_START) begin
                        n_n     = w_len_sat;
                        n_x     = '0;
                        n_width = WW'(1);
                        n_src   = 1'b0;
                        n_state = ST_INIT;
                    end else if (r_state == ST_WAIT) begin
                        // take the right head on a true answer, else the left
                        w_we    = 1'b1;
                        w_wdata = s_axis_tdata[LEN_W] ? r_rhead : r_lhead;
                        n_op    = r_op + 1'b1;
                        if (s_axis_tdata[LEN_W]) begin
                            n_rp = r_rp + 1'b1;
                        end else begin
                            n_lp = r_lp + 1'b1;
                        end
                        n_state = ST_HEAD;
                    end
                end
            end
            ST_INIT: begin
                // load the identity order into bank 0
                if (r_x < r_n) begin
                    w_we    = 1'b1;
                    w_wbank = 1'b0;
                    w_waddr = AW'(r_x);
                    w_wdata = AW'(r_x);
                    n_x     = r_x + 1'b1;
                end else begin
                    n_state = ST_PASS;
                end
            end
            ST_PASS: begin
                if (r_width < WW'(r_n)) begin
                    n_pstart = '0;
                    n_state  = ST_OPEN;
                end else begin
                    n_x     = '0;
                    n_state = (r_n == '0) ? ST_IDLE : ST_EMRD;
                end
            end
            ST_OPEN: begin
                if (r_pstart < w_n_ext) begin
                    n_le    = CW'((w_end_l < w_n_ext) ? w_end_l : w_n_ext);
                    n_re    = CW'((w_end_r < w_n_ext) ? w_end_r : w_n_ext);
                    n_lp    = CW'(r_pstart);
                    n_rp    = CW'((w_end_l < w_n_ext) ? w_end_l : w_n_ext);
                    n_op    = CW'(r_pstart);
                    n_state = ST_HEAD;
                end else begin
                    // pass done: swap banks, double the run width
                    n_src   = !r_src;
                    n_width = {r_width[WW-2:0], 1'b0};
                    n_state = ST_PASS;
                end
            end
            ST_HEAD: begin
                if (w_l_has && w_r_has) begin
                    n_state = ST_CMPL;
                end else if (w_l_has || w_r_has) begin
                    n_state = ST_COPY;
                end else begin
                    n_pstart = w_end_r;
                    n_state  = ST_OPEN;
                end
            end
            ST_COPY: begin
                // copy one tail item without asking
                w_we = 1'b1;
                n_op = r_op + 1'b1;
                if (w_l_has) begin
                    n_lp = r_lp + 1'b1;
                end else begin
                    n_rp = r_rp + 1'b1;
                end
                n_state = ST_HEAD;
            end
            ST_CMPL: begin
                n_state = ST_CMPR;
            end
            ST_CMPR: begin
                n_lhead = w_rdata;
                n_state = ST_REQ;
            end
            ST_REQ: begin
                // issue the compare request once the output is free
                if (w_out_free) begin
                    n_rhead     = w_rdata;
                    w_load      = 1'b1;
                    w_load_kind = KIND_REQ;
                    w_load_a    = r_reverse ? IDX_W'(r_lhead) : IDX_W'(w_rdata);
                    w_load_b    = r_reverse ? IDX_W'(w_rdata) : IDX_W'(r_lhead);
                    n_state     = ST_WAIT;
                end
            end
            ST_EMRD: begin
                n_state = ST_EMLD;
            end
            ST_EMLD: begin
                // emit one sorted position
                if (w_out_free) begin
                    w_load      = 1'b1;
                    w_load_kind = KIND_POS;
                    w_load_s    = IDX_W'(w_rdata);
                    w_load_last = w_is_last;
                    n_x         = r_x + 1'b1;
                    n_state     = w_is_last ? ST_IDLE : ST_EMRD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_width  <= n_width;
        r_pstart <= n_pstart;
        r_le     <= n_le;
        r_re     <= n_re;
        r_lp     <= n_lp;
        r_rp     <= n_rp;
        r_op     <= n_op;
        r_x      <= n_x;
        r_src    <= n_src;
        r_lhead  <= n_lhead;
        r_rhead  <= n_rhead;
        if (w_load) begin
            r_out_kind <= w_load_kind;
            r_out_a    <= w_load_a;
            r_out_b    <= w_load_b;
            r_out_s    <= w_load_s;
            r_out_last <= w_load_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {(OUT_DW - 3 * IDX_W)'(0), r_out_s, r_out_b, r_out_a};

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_REVERSE)) begin
            r_reverse <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_REVERSE) ? 32'(r_reverse) : 32'd0;

    // Checks
    `MSE_ASSERT_IMPLIES(a_wait_heads, i_clk, i_rst_n, (r_state == ST_WAIT),
        (w_l_has && w_r_has), "request open with an empty run")
    `MSE_ASSERT_IMPLIES(a_merge_balance, i_clk, i_rst_n,
        ((r_state == ST_HEAD) || (r_state == ST_WAIT)), w_bal_ok,
        "merge output position out of step with run heads")
    `MSE_ASSERT_IMPLIES(a_width_onehot, i_clk, i_rst_n, (r_state != ST_IDLE),
        $onehot(r_width), "run width not a power of two")
    `MSE_ASSERT_NEXT(a_req_shown, i_clk, i_rst_n, ((r_state == ST_REQ) && w_out_free),
        ((r_state == ST_WAIT) && m_axis_tvalid && (m_axis_tuser == KIND_REQ)),
        "compare request not presented while waiting")

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Merge sort testbench
// Feeds sort starts and compare answers to the block, answers each compare
// from a key table held here, and checks every request and sorted position
// against a cycle-free software merge kept in step with accepted commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import mse_pkg::*;

    localparam int SORT_CAP      = 64;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 500;
    localparam int HOLD_AT       = 120;
    localparam int CYCLE_LIMIT   = 5000000;

    typedef struct packed {
        logic            cmd;
        logic            ans;
        logic [LEN_W-1:0] len;
    } t_sort_cmd;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] lhs;
        logic [IDX_W-1:0] rhs;
        logic [IDX_W-1:0] pos;
        logic             last;
    } t_merge_out;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic [IN_DW-1:0]  s_axis_tdata  = '0;    // [6:0] length, [7] answer
    logic              s_axis_tuser  = 1'b0;  // [0] command
    logic              m_axis_tready = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [31:0]       pwdata        = '0;
    wire               s_axis_tready;
    wire               m_axis_tvalid;
    wire [OUT_DW-1:0]  m_axis_tdata;          // [5:0] first, [11:6] second,
                                              // [17:12] sorted position
    wire               m_axis_tuser;          // [0] kind
    wire               m_axis_tlast;
    wire [31:0]        prdata;
    wire               pready;

    merge_sort_external_compare #(
        .MAX_ITEMS(SORT_CAP)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Software merge state, advanced once per accepted command
    logic [IDX_W-1:0] perm_mem [SORT_CAP];
    logic [IDX_W-1:0] merge_buf [SORT_CAP];
    int unsigned      run_len;
    int unsigned      pair_base;
    int unsigned      lhead;
    int unsigned      rhead;
    int unsigned      wr_pos;
    int unsigned      lstop;
    int unsigned      rstop;
    int unsigned      sort_len    = 0;
    bit               ans_pending = 1'b0;
    bit               pair_open   = 1'b0;
    bit               rev_mode    = 1'b0;
    logic [IDX_W-1:0] asked_lhs;
    logic [IDX_W-1:0] asked_rhs;
    t_merge_out       merge_out_q [$];

    // Stimulus bookkeeping
    t_sort_cmd   cmd_q [$];
    t_sort_cmd   feed_item;
    int          sort_key [SORT_CAP];
    int unsigned pushed        = 0;
    int unsigned accepted      = 0;
    int unsigned counted_items = 0;
    int unsigned stray_answers = 0;
    int unsigned n_requests    = 0;
    int unsigned n_positions   = 0;
    int unsigned n_sorts       = 0;
    int unsigned errors        = 0;
    int unsigned cycles        = 0;
    int          feed_gap      = 0;
    int          stall_cnt     = 0;
    int          hold_cnt      = 0;
    bit          hold_done     = 1'b0;
    bit          quiet         = 1'b0;
    t_merge_out  got;
    t_merge_out  want;

    function automatic void push_result(logic kind, logic [IDX_W-1:0] lhs,
                                        logic [IDX_W-1:0] rhs,
                                        logic [IDX_W-1:0] pos, logic last);
        t_merge_out r;
        r.kind = kind;
        r.lhs  = lhs;
        r.rhs  = rhs;
        r.pos  = pos;
        r.last = last;
        merge_out_q.push_back(r);
    endfunction

    // Run merge passes until two run heads need a compare or the sort ends
    function automatic void merge_until_compare();
        int unsigned n;
        n = sort_len;
        while (run_len < n) begin
            while (pair_base < n) begin
                if (!pair_open) begin
                    lstop     = (pair_base + run_len < n) ? pair_base + run_len : n;
                    rstop     = (pair_base + 2 * run_len < n) ? pair_base + 2 * run_len : n;
                    lhead     = pair_base;
                    rhead     = lstop;
                    wr_pos    = pair_base;
                    pair_open = 1'b1;
                end
                if (lhead < lstop && rhead < rstop) begin
                    if (rev_mode) begin
                        asked_lhs = perm_mem[lhead];
                        asked_rhs = perm_mem[rhead];
                    end else begin
                        asked_lhs = perm_mem[rhead];
                        asked_rhs = perm_mem[lhead];
                    end
                    push_result(KIND_REQ, asked_lhs, asked_rhs, '0, 1'b0);
                    ans_pending = 1'b1;
                    return;
                end
                // copy run tails without asking
                while (lhead < lstop) begin
                    merge_buf[wr_pos] = perm_mem[lhead];
                    wr_pos++;
                    lhead++;
                end
                while (rhead < rstop) begin
                    merge_buf[wr_pos] = perm_mem[rhead];
                    wr_pos++;
                    rhead++;
                end
                pair_base += 2 * run_len;
                pair_open = 1'b0;
            end
            for (int x = 0; x < n; x++) perm_mem[x] = merge_buf[x];
            run_len *= 2;
            pair_base = 0;
        end
        for (int x = 0; x < n; x++)
            push_result(KIND_POS, '0, '0, perm_mem[x], (x + 1 == n));
        sort_len = 0;
    endfunction

    function automatic void sort_step(t_sort_cmd it);
        int unsigned n;
        if (it.cmd == CMD_START) begin
            n = (it.len > SORT_CAP) ? SORT_CAP : it.len;
            for (int x = 0; x < n; x++) perm_mem[x] = IDX_W'(x);
            sort_len    = n;
            run_len     = 1;
            pair_base   = 0;
            pair_open   = 1'b0;
            ans_pending = 1'b0;
            merge_until_compare();
        end else if (ans_pending) begin
            ans_pending = 1'b0;
            if (it.ans) begin
                merge_buf[wr_pos] = perm_mem[rhead];
                rhead++;
            end else begin
                merge_buf[wr_pos] = perm_mem[lhead];
                lhead++;
            end
            wr_pos++;
            merge_until_compare();
        end
    endfunction

    // Feed queued commands, with random idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            feed_gap = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (feed_gap > 0) begin
                feed_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (cmd_q.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
                feed_gap = $urandom_range(0, 15);
                s_axis_tvalid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                feed_item = cmd_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {feed_item.ans, feed_item.len};
                s_axis_tuser  <= feed_item.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Advance the software merge on each accepted command
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sort_step(t_sort_cmd'{cmd: s_axis_tuser, ans: s_axis_tdata[7],
                                  len: s_axis_tdata[6:0]});
            accepted++;
        end
    end

    // Receiver: random stall bursts and one long hold-off
    always @(posedge i_clk) begin
        if (!hold_done && accepted >= HOLD_AT) begin
            hold_cnt  = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_cnt = $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Check each accepted result against the oldest predicted one
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{kind: m_axis_tuser, lhs: m_axis_tdata[5:0], rhs: m_axis_tdata[11:6],
                    pos: m_axis_tdata[17:12], last: m_axis_tlast};
            if (got.kind == KIND_REQ) n_requests++;
            else n_positions++;
            if (got.kind == KIND_POS && got.last) n_sorts++;
            if (merge_out_q.size() == 0) begin
                $error("result with nothing pending: kind %0d tdata 0x%06h",
                       got.kind, m_axis_tdata);
                errors++;
            end else begin
                want = merge_out_q.pop_front();
                if (got.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, got.kind);
                    errors++;
                end
                if (got.lhs !== want.lhs) begin
                    $error("first_index: expected %0d, got %0d", want.lhs, got.lhs);
                    errors++;
                end
                if (got.rhs !== want.rhs) begin
                    $error("second_index: expected %0d, got %0d", want.rhs, got.rhs);
                    errors++;
                end
                if (got.pos !== want.pos) begin
                    $error("sorted_index: expected %0d, got %0d", want.pos, got.pos);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, merge_out_q.size());
            $display("tb: errors");
            $finish;
        end
    end

    // Queue one command and hold until the block takes it
    task automatic send_cmd(logic cmd, logic [LEN_W-1:0] len, logic ans);
        t_sort_cmd it;
        it.cmd = cmd;
        it.len = len;
        it.ans = ans;
        if (cmd == CMD_ANSWER && !ans_pending) stray_answers++;
        else counted_items++;
        cmd_q.push_back(it);
        pushed++;
        do @(negedge i_clk); while (accepted != pushed);
    endtask

    task automatic fill_keys(int span, bit ascending);
        for (int i = 0; i < SORT_CAP; i++)
            sort_key[i] = ascending ? i : $urandom_range(0, span);
    endtask

    // Start a sort and answer its compares from the key table
    task automatic run_sort(int n, bit noisy);
        logic ans;
        send_cmd(CMD_START, LEN_W'(n), 1'($urandom_range(0, 1)));
        while (ans_pending) begin
            if (noisy && $urandom_range(0, 49) == 0) return;
            ans = (sort_key[asked_lhs] < sort_key[asked_rhs]);
            if (noisy && $urandom_range(0, 29) == 0) ans = ~ans;
            send_cmd(CMD_ANSWER, LEN_W'($urandom_range(0, 127)), ans);
        end
    endtask

    task automatic random_phase(int n);
        int unsigned stop_at;
        int          pick;
        stop_at = counted_items + n;
        while (counted_items < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 6 && !ans_pending) begin
                send_cmd(CMD_ANSWER, LEN_W'($urandom_range(0, 127)),
                         1'($urandom_range(0, 1)));
            end else if (pick < 12) begin
                send_cmd(CMD_START, LEN_W'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                fill_keys($urandom_range(0, 7), 1'b0);
                run_sort((pick < 20) ? $urandom_range(10, 20) : $urandom_range(2, 9), 1'b1);
            end
        end
        // close any sort left open
        while (ans_pending)
            send_cmd(CMD_ANSWER, LEN_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    endtask

    // Wait until every predicted result is out, then let the block go quiet
    task automatic settle();
        do @(negedge i_clk); while (merge_out_q.size() != 0 || accepted != pushed);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [APB_AW-1:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic reg_read(logic [APB_AW-1:0] addr, output logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_reverse(bit v);
        logic [31:0] rd;
        settle();
        reg_write(ADDR_REVERSE, {31'b0, v});
        rev_mode = v;
        reg_read(ADDR_REVERSE, rd);
        if (rd !== {31'b0, v}) begin
            $error("reverse readback: expected %0d, got 0x%08h", v, rd);
            errors++;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_reverse(1'b0);

        // Empty sort, ignored answers, single item
        send_cmd(CMD_START, LEN_W'(0), 1'b1);
        send_cmd(CMD_ANSWER, 7'h7f, 1'b1);
        send_cmd(CMD_ANSWER, 7'h00, 1'b0);
        send_cmd(CMD_START, LEN_W'(1), 1'b0);
        // Two items, right key smaller
        sort_key[0] = 5;
        sort_key[1] = 3;
        run_sort(2, 1'b0);
        // Equal keys keep their original order
        fill_keys(0, 1'b0);
        run_sort(3, 1'b0);
        // Oversized start, dropped by a new start while a compare is open
        fill_keys(0, 1'b1);
        send_cmd(CMD_START, 7'h7f, 1'b0);
        send_cmd(CMD_ANSWER, 7'h55, 1'b0);
        fill_keys(3, 1'b0);
        run_sort(5, 1'b0);

        set_reverse(1'b1);
        random_phase(100);

        // Full-size sort from a saturated length, ascending keys
        set_reverse(1'b0);
        fill_keys(0, 1'b1);
        run_sort($urandom_range(SORT_CAP, 127), 1'b0);
        random_phase(60);

        // Last stretch without idling
        set_reverse(1'b1);
        quiet = 1'b1;
        random_phase(50);

        settle();
        if (merge_out_q.size() != 0) begin
            $error("%0d results never arrived", merge_out_q.size());
            errors++;
        end
        $display("run covered %0d commands plus %0d ignored answers, %0d sorts done",
                 counted_items, stray_answers, n_sorts);
        $display("results checked: %0d compare requests, %0d sorted positions",
                 n_requests, n_positions);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
